/* design/cpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared constants, request codes and types of the crosspoint matrix
// controller.
// ----------------------------------------------------------------------------
package cpm_pkg;

	localparam int NUM_IN  = 32;
	localparam int NUM_OUT = 16;
	localparam int IN_W    = $clog2(NUM_IN);
	localparam int OUT_W   = $clog2(NUM_OUT);
	localparam int HALF_IN = NUM_IN / 2;
	localparam int POS_W   = $clog2(HALF_IN);

	localparam logic [2:0] REQ_CONNECT    = 3'd0;
	localparam logic [2:0] REQ_DISCONNECT = 3'd1;
	localparam logic [2:0] REQ_CLEAR_OUT  = 3'd2;
	localparam logic [2:0] REQ_QUERY      = 3'd3;
	localparam logic [2:0] REQ_CLEAR_ALL  = 3'd4;
	localparam logic [2:0] REQ_UP_START   = 3'd5;
	localparam logic [2:0] REQ_UP_PAIR    = 3'd6;

	localparam logic CHIP_STROBE_BIT = 1'b1;

	typedef struct packed {
		logic              rd_en;
		logic [OUT_W-1:0]  rd_addr;
		logic              wr_en;
		logic [OUT_W-1:0]  wr_addr;
		logic [NUM_IN-1:0] wr_data;
		logic              clr_all;
	} mem_req_t;

endpackage

/* design/cpm_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface cpm_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] in_sel;
	logic [7:0] out_sel;
	logic       exclusive;
	logic       allow_split;

	modport source (
		output valid, req_type, in_sel, out_sel, exclusive, allow_split,
		input  ready
	);
	modport sink (
		input  valid, req_type, in_sel, out_sel, exclusive, allow_split,
		output ready
	);
endinterface

/* design/cpm_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_res_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface cpm_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        connected;
	logic [31:0] cmd_word;
	logic        cmd_valid;
	logic        reset_strobe;
	logic        last;

	modport source (
		output valid, status, connected, cmd_word, cmd_valid, reset_strobe, last,
		input  ready
	);
	modport sink (
		input  valid, status, connected, cmd_word, cmd_valid, reset_strobe, last,
		output ready
	);
endinterface

/* design/crosspoint_matrix_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crosspoint_matrix_controller_top
// Connection table and command word generator for a 32-input by 16-output
// crosspoint matrix built from four 16x8 chips.
// ----------------------------------------------------------------------------
// One request is handled at a time; the request channel is ready again once
// the last item of the previous request sits in the result register. Clear
// output, clear all, upload start and every rejected request go straight to
// the reply. Disconnect and query do one mask memory read, then the reply.
// Connect runs a scan that reads all 16 output masks through the single
// memory read port to enforce the split rule. Upload pair reads both masks,
// then walks the 16 input positions in order, one per cycle unless the result
// side stalls, emitting a command word at each position with new data and
// ending after the last such position.
// ----------------------------------------------------------------------------
module crosspoint_matrix_controller_top (
	input  logic      clk,
	input  logic      arst_n,
	cpm_req_if.sink   req,
	cpm_res_if.source res
);

	cpm_pkg::mem_req_t          mreq;
	logic [cpm_pkg::NUM_IN-1:0] rd_data;

	cpm_mask_mem u_mask_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

	cpm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.res     (res),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

endmodule

/* design/cpm_mask_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_mask_mem
// Connection mask memory, one entry per output, registered read port and
// per-entry valid bits so that clear all resets every entry in one write.
// ----------------------------------------------------------------------------
module cpm_mask_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cpm_pkg::mem_req_t         mreq,
	output logic [cpm_pkg::NUM_IN-1:0] rd_data
);

	logic [cpm_pkg::NUM_IN-1:0]  ram [cpm_pkg::NUM_OUT];
	logic [cpm_pkg::NUM_OUT-1:0] valid_q;
	logic [cpm_pkg::NUM_IN-1:0]  rd_data_s1;
	logic                        rd_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (mreq.rd_en) begin
				rd_valid_s1 <= valid_q[mreq.rd_addr];
			end
			if (mreq.clr_all) begin
				valid_q <= '0;
			end else if (mreq.wr_en) begin
				valid_q[mreq.wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			ram[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rd_data_s1 <= ram[mreq.rd_addr];
		end
	end

	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

/* design/cpm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_ctrl
// Request sequencer: range checks, pin fix, split scan over the mask memory,
// read-modify-write of one mask, upload walk and the result register.
// ----------------------------------------------------------------------------
module cpm_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	cpm_req_if.sink                    req,
	cpm_res_if.source                  res,
	output cpm_pkg::mem_req_t          mreq,
	input  logic [cpm_pkg::NUM_IN-1:0] rd_data
);

	localparam int NI = cpm_pkg::NUM_IN;
	localparam int OW = cpm_pkg::OUT_W;
	localparam int IW = cpm_pkg::IN_W;
	localparam int HI = cpm_pkg::HALF_IN;
	localparam int PW = cpm_pkg::POS_W;
	localparam logic [OW-1:0] OUT_LAST = OW'(cpm_pkg::NUM_OUT - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_READ  = 6'b000100,
		S_READB = 6'b001000,
		S_WALK  = 6'b010000,
		S_REPLY = 6'b100000
	} state_t;

	function automatic logic [IW-1:0] pin_fix(input logic [IW-1:0] pin);
		logic [IW-1:0] r;
		r = pin;
		if ((pin >= 5'd6 && pin <= 5'd11) || (pin >= 5'd22 && pin <= 5'd27)) begin
			r = pin + 5'd2;
		end else if ((pin >= 5'd12 && pin <= 5'd13) || (pin >= 5'd28 && pin <= 5'd29)) begin
			r = pin - 5'd6;
		end
		return r;
	endfunction

	state_t         state_q;
	logic [2:0]     req_q;
	logic [IW-1:0]  isel_q;
	logic [OW-1:0]  osel_q;
	logic           excl_q;
	logic           split_q;
	logic [IW-1:0]  m_q;
	logic [OW-1:0]  idx_q;
	logic           conflict_q;
	logic [NI-1:0]  mask_q;
	logic [NI-1:0]  a_q;
	logic [NI-1:0]  b_q;
	logic [HI-1:0]  f_q;
	logic [31:0]    last_cmd_q;
	logic           rep_status_q;
	logic           rep_conn_q;
	logic           rep_strobe_q;

	logic           res_valid_q;
	logic           res_status_q;
	logic           res_conn_q;
	logic [31:0]    res_cmd_q;
	logic           res_cmd_valid_q;
	logic           res_strobe_q;
	logic           res_last_q;

	logic           acc;
	logic           in_ok;
	logic           out_ok;
	logic           pair_ok;
	logic           conn_ok;
	logic           can_emit;
	logic           res_load;
	logic           scan_hit;
	logic           conflict_now;
	logic [NI-1:0]  mask_use;
	logic [NI-1:0]  mbit;
	logic [HI-1:0]  pos_f;
	logic [PW-1:0]  pos;
	logic           fresh;
	logic [HI-1:0]  f_rest;
	logic [7:0]     chip_byte;
	logic [31:0]    walk_cmd;

	assign acc      = req.valid && req.ready;
	assign in_ok    = req.in_sel < 8'(cpm_pkg::NUM_IN);
	assign out_ok   = req.out_sel < 8'(cpm_pkg::NUM_OUT);
	assign pair_ok  = req.out_sel < 8'(cpm_pkg::NUM_OUT / 2);
	assign conn_ok  = in_ok && out_ok;
	assign can_emit = !res_valid_q || res.ready;
	assign res_load = can_emit && ((state_q == S_REPLY) || (state_q == S_WALK && fresh));

	assign scan_hit     = (idx_q != osel_q) && rd_data[m_q] && !split_q;
	assign conflict_now = conflict_q || scan_hit;
	assign mask_use     = (idx_q == osel_q) ? rd_data : mask_q;
	assign mbit         = NI'(1) << m_q;

	assign pos_f     = a_q[HI-1:0] | a_q[NI-1:HI] | rd_data[HI-1:0] | rd_data[NI-1:HI];
	assign pos       = idx_q[PW-1:0];
	assign fresh     = f_q[pos];
	assign f_rest    = f_q & ~(HI'(1) << pos);
	assign chip_byte = {cpm_pkg::CHIP_STROBE_BIT, osel_q[2:0], pos};
	assign walk_cmd  = {
		b_q[{1'b1, pos}] ? chip_byte : last_cmd_q[31:24],
		b_q[{1'b0, pos}] ? chip_byte : last_cmd_q[23:16],
		a_q[{1'b1, pos}] ? chip_byte : last_cmd_q[15:8],
		a_q[{1'b0, pos}] ? chip_byte : last_cmd_q[7:0]
	};

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (req.req_type)
						cpm_pkg::REQ_CONNECT: begin
							mreq.rd_en   = conn_ok;
							mreq.rd_addr = '0;
						end
						cpm_pkg::REQ_DISCONNECT, cpm_pkg::REQ_QUERY: begin
							mreq.rd_en   = conn_ok;
							mreq.rd_addr = req.out_sel[OW-1:0];
						end
						cpm_pkg::REQ_CLEAR_OUT: begin
							mreq.wr_en   = out_ok;
							mreq.wr_addr = req.out_sel[OW-1:0];
							mreq.wr_data = '0;
						end
						cpm_pkg::REQ_CLEAR_ALL: begin
							mreq.clr_all = 1'b1;
						end
						cpm_pkg::REQ_UP_PAIR: begin
							mreq.rd_en   = pair_ok;
							mreq.rd_addr = req.out_sel[OW-1:0];
						end
						default: begin
							mreq.rd_en = 1'b0;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (idx_q != OUT_LAST) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = idx_q + OW'(1);
				end else if (!conflict_now) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = osel_q;
					mreq.wr_data = excl_q ? mbit : (mask_use | mbit);
				end
			end
			S_READ: begin
				if (req_q == cpm_pkg::REQ_DISCONNECT) begin
					mreq.wr_en   = rd_data[isel_q];
					mreq.wr_addr = osel_q;
					mreq.wr_data = rd_data & ~(NI'(1) << isel_q);
				end else if (req_q == cpm_pkg::REQ_UP_PAIR) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = {1'b1, osel_q[OW-2:0]};
				end
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			req_q           <= '0;
			isel_q          <= '0;
			osel_q          <= '0;
			excl_q          <= 1'b0;
			split_q         <= 1'b0;
			m_q             <= '0;
			idx_q           <= '0;
			conflict_q      <= 1'b0;
			mask_q          <= '0;
			a_q             <= '0;
			b_q             <= '0;
			f_q             <= '0;
			last_cmd_q      <= '0;
			rep_status_q    <= 1'b0;
			rep_conn_q      <= 1'b0;
			rep_strobe_q    <= 1'b0;
			res_valid_q     <= 1'b0;
			res_status_q    <= 1'b0;
			res_conn_q      <= 1'b0;
			res_cmd_q       <= '0;
			res_cmd_valid_q <= 1'b0;
			res_strobe_q    <= 1'b0;
			res_last_q      <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						req_q      <= req.req_type;
						isel_q     <= req.in_sel[IW-1:0];
						osel_q     <= req.out_sel[OW-1:0];
						excl_q     <= req.exclusive;
						split_q    <= req.allow_split;
						m_q        <= pin_fix(req.in_sel[IW-1:0]);
						idx_q      <= '0;
						conflict_q <= 1'b0;
						rep_conn_q <= 1'b0;
						unique case (req.req_type)
							cpm_pkg::REQ_CONNECT: begin
								rep_status_q <= 1'b1;
								rep_strobe_q <= 1'b0;
								state_q      <= conn_ok ? S_SCAN : S_REPLY;
							end
							cpm_pkg::REQ_DISCONNECT, cpm_pkg::REQ_QUERY: begin
								rep_status_q <= 1'b1;
								rep_strobe_q <= 1'b0;
								state_q      <= conn_ok ? S_READ : S_REPLY;
							end
							cpm_pkg::REQ_CLEAR_OUT: begin
								rep_status_q <= !out_ok;
								rep_strobe_q <= 1'b0;
								state_q      <= S_REPLY;
							end
							cpm_pkg::REQ_CLEAR_ALL: begin
								rep_status_q <= 1'b0;
								rep_strobe_q <= 1'b0;
								state_q      <= S_REPLY;
							end
							cpm_pkg::REQ_UP_START: begin
								rep_status_q <= 1'b0;
								rep_strobe_q <= 1'b1;
								last_cmd_q   <= '0;
								state_q      <= S_REPLY;
							end
							cpm_pkg::REQ_UP_PAIR: begin
								rep_status_q <= 1'b1;
								rep_strobe_q <= 1'b0;
								state_q      <= pair_ok ? S_READ : S_REPLY;
							end
							default: begin
								rep_status_q <= 1'b1;
								rep_strobe_q <= 1'b0;
								state_q      <= S_REPLY;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						conflict_q <= 1'b1;
					end
					if (idx_q == osel_q) begin
						mask_q <= rd_data;
					end
					if (idx_q == OUT_LAST) begin
						rep_status_q <= conflict_now;
						state_q      <= S_REPLY;
					end else begin
						idx_q <= idx_q + OW'(1);
					end
				end
				S_READ: begin
					unique case (req_q)
						cpm_pkg::REQ_DISCONNECT: begin
							rep_status_q <= !rd_data[isel_q];
							state_q      <= S_REPLY;
						end
						cpm_pkg::REQ_QUERY: begin
							rep_status_q <= 1'b0;
							rep_conn_q   <= rd_data[isel_q];
							state_q      <= S_REPLY;
						end
						default: begin
							a_q     <= rd_data;
							state_q <= S_READB;
						end
					endcase
				end
				S_READB: begin
					if (pos_f == '0) begin
						rep_status_q <= 1'b0;
						state_q      <= S_REPLY;
					end else begin
						b_q     <= rd_data;
						f_q     <= pos_f;
						idx_q   <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!fresh) begin
						idx_q <= idx_q + OW'(1);
					end else if (can_emit) begin
						res_status_q    <= 1'b0;
						res_conn_q      <= 1'b0;
						res_cmd_q       <= walk_cmd;
						res_cmd_valid_q <= 1'b1;
						res_strobe_q    <= 1'b0;
						res_last_q      <= (f_rest == '0);
						last_cmd_q      <= walk_cmd;
						f_q             <= f_rest;
						if (f_rest == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + OW'(1);
						end
					end
				end
				S_REPLY: begin
					if (can_emit) begin
						res_status_q    <= rep_status_q;
						res_conn_q      <= rep_conn_q;
						res_cmd_q       <= '0;
						res_cmd_valid_q <= 1'b0;
						res_strobe_q    <= rep_strobe_q;
						res_last_q      <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.connected    = res_conn_q;
	assign res.cmd_word     = res_cmd_q;
	assign res.cmd_valid    = res_cmd_valid_q;
	assign res.reset_strobe = res_strobe_q;
	assign res.last         = res_last_q;

endmodule
